>>> hdl/sfcp_pkg.sv
// Shared types and constants of the sync-framed command parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sfcp_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] dev_t;
    typedef logic [3:0] cmd_t;

    // One decoded frame as it leaves the parser.
    typedef struct packed {
        logic frame_status;
        dev_t device_id;
        cmd_t command;
    } result_t;

    localparam byte_t SyncByte = 8'hFF;

    localparam dev_t DevPick    = 3'd2;
    localparam dev_t DevShoot   = 3'd3;
    localparam dev_t DevRanging = 3'd4;

    localparam logic StatusOk     = 1'b0;
    localparam logic StatusBadSum = 1'b1;

    localparam cmd_t CmdNone         = 4'd0;
    localparam cmd_t CmdGetBall      = 4'd1;
    localparam cmd_t CmdDownFromHold = 4'd6;
    localparam cmd_t CmdShoot        = 4'd7;
    localparam cmd_t CmdReport       = 4'd8;

    // First payload byte that marks a valid command request.
    localparam byte_t ReqMarker = 8'h01;

endpackage

`default_nettype wire

>>> hdl/sfcp_if.sv
// Valid/ready channel interfaces of the sync-framed command parser.
// Depends on sfcp_pkg for the payload types.
`default_nettype none

interface sfcp_rx_if;
    import sfcp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfcp_res_if;
    import sfcp_pkg::*;

    logic valid;
    logic ready;
    logic frame_status;
    dev_t device_id;
    cmd_t command;

    modport source (output valid, output frame_status, output device_id,
                    output command, input ready);
    modport sink (input valid, input frame_status, input device_id,
                  input command, output ready);
endinterface

`default_nettype wire

>>> hdl/sfcp_parser.sv
// Frame parser state machine: sync hunt, header, payload, checksum test.
// Depends on sfcp_pkg.
`default_nettype none

module sfcp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire sfcp_pkg::byte_t rx_byte,
    output logic                 res_valid,
    output sfcp_pkg::result_t    res_data
);
    import sfcp_pkg::*;

    localparam logic [2:0] PhSync1   = 3'd0;
    localparam logic [2:0] PhSync2   = 3'd1;
    localparam logic [2:0] PhId      = 3'd2;
    localparam logic [2:0] PhLenH    = 3'd3;
    localparam logic [2:0] PhLenL    = 3'd4;
    localparam logic [2:0] PhPayload = 3'd5;
    localparam logic [2:0] PhCheck   = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    dev_t        device_reg, device_next;
    logic [15:0] sum_reg, sum_next;
    byte_t       len_high_reg, len_high_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;
    byte_t       first_reg, first_next;
    byte_t       second_reg, second_next;

    logic [15:0] sum_add;
    logic [15:0] count_inc;
    logic [8:0]  fold1;
    byte_t       fold2;
    byte_t       residue;
    logic        sum_ok;
    cmd_t        decoded;
    logic        id_valid;

    assign sum_add   = sum_reg + {8'd0, rx_byte};
    assign count_inc = count_reg + 16'd1;
    assign id_valid  = (rx_byte == {5'd0, DevPick}) || (rx_byte == {5'd0, DevShoot})
                    || (rx_byte == {5'd0, DevRanging});

    // Modulo 255 by folding: 256 is congruent to 1, so the two bytes are added
    // and the carry folded back in; a final 255 stands for zero.
    assign fold1   = {1'b0, sum_reg[15:8]} + {1'b0, sum_reg[7:0]};
    assign fold2   = fold1[7:0] + {7'd0, fold1[8]};
    assign residue = (fold2 == 8'hFF) ? 8'd0 : fold2;
    assign sum_ok  = (residue == rx_byte);

    always_comb
    begin
        decoded = CmdNone;
        if (first_reg == ReqMarker)
        begin
            unique case (device_reg)
                DevPick:
                begin
                    if ((second_reg >= {4'd0, CmdGetBall})
                        && (second_reg <= {4'd0, CmdDownFromHold}))
                    begin
                        decoded = second_reg[3:0];
                    end
                end
                DevShoot:   decoded = CmdShoot;
                DevRanging: decoded = CmdReport;
                default:    decoded = CmdNone;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        device_next   = device_reg;
        sum_next      = sum_reg;
        len_high_next = len_high_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        res_valid     = 1'b0;
        res_data.frame_status = sum_ok ? StatusOk : StatusBadSum;
        res_data.device_id    = device_reg;
        res_data.command      = sum_ok ? decoded : CmdNone;

        if (accept)
        begin
            unique case (phase_reg)
                PhSync1:
                begin
                    if (rx_byte == SyncByte)
                    begin
                        phase_next = PhSync2;
                        sum_next   = 16'd0;
                        count_next = 16'd0;
                    end
                end
                PhSync2:
                begin
                    phase_next = (rx_byte == SyncByte) ? PhId : PhSync1;
                end
                PhId:
                begin
                    if (id_valid)
                    begin
                        device_next = rx_byte[2:0];
                        sum_next    = sum_add;
                        phase_next  = PhLenH;
                    end
                    else
                    begin
                        phase_next = PhSync1;
                    end
                end
                PhLenH:
                begin
                    sum_next      = sum_add;
                    len_high_next = rx_byte;
                    phase_next    = PhLenL;
                end
                PhLenL:
                begin
                    sum_next    = sum_add;
                    length_next = {len_high_reg, rx_byte};
                    phase_next  = PhPayload;
                end
                PhPayload:
                begin
                    sum_next = sum_add;
                    if (count_reg == 16'd0)
                    begin
                        first_next = rx_byte;
                    end
                    else if (count_reg == 16'd1)
                    begin
                        second_next = rx_byte;
                    end
                    count_next = count_inc;
                    // A zero length still takes one byte: the count is one
                    // by then, which already passes the compare.
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PhCheck;
                    end
                end
                PhCheck:
                begin
                    res_valid  = 1'b1;
                    phase_next = PhSync1;
                end
                default:
                begin
                    phase_next = PhSync1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PhSync1;
            device_reg   <= 3'd0;
            sum_reg      <= 16'd0;
            len_high_reg <= 8'd0;
            length_reg   <= 16'd0;
            count_reg    <= 16'd0;
            first_reg    <= 8'd0;
            second_reg   <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            device_reg   <= device_next;
            sum_reg      <= sum_next;
            len_high_reg <= len_high_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
        end
    end

    a_result_only_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PhCheck))
        else $error("result raised outside the check phase");

    a_check_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PhCheck)) |=> (phase_reg == PhSync1))
        else $error("parser did not return to sync hunt after check byte");

    a_payload_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PhPayload) |-> ((count_reg < length_reg) || (count_reg == 16'd0)))
        else $error("payload count ran past the frame length");

endmodule

`default_nettype wire

>>> hdl/sfcp_out_buf.sv
// Two-entry result buffer that parts the parser from the output handshake.
// Depends on sfcp_pkg.
`default_nettype none

module sfcp_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sfcp_pkg::result_t push_data,
    output logic                   can_push,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sfcp_pkg::result_t      out_data
);
    import sfcp_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign can_push  = (count_reg != 2'd2);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("result pushed into a full buffer");

    a_pointers_track_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd0) || (count_reg == 2'd2)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("buffer pointers disagree with the fill count");

endmodule

`default_nettype wire

>>> hdl/sync_framed_command_parser.sv
// Top level of the sync-framed command parser.
// Depends on sfcp_pkg, sfcp_if, sfcp_parser and sfcp_out_buf.
//
// The block takes one received byte per word on the rx channel and looks for
// frames of the form 0xFF 0xFF, device id (2, 3 or 4), 16-bit big-endian
// length, payload, check byte. A length of zero is treated as one payload
// byte. The check byte is compared with the 16-bit wrapping sum of the id,
// the length bytes and the payload, reduced modulo 255. When the check byte
// arrives the block delivers one word on the frame channel with the status
// (0 match, 1 mismatch), the device id and the command decoded from the first
// two payload bytes; on a mismatch the command is 0. No other byte produces a
// word. The block accepts one byte every clock cycle while the output buffer
// has a free word: each byte costs a single state update of the parser, and a
// result is registered into the output buffer when its check byte is accepted.
// A two-word output buffer sits between the parser and the frame channel, so
// rx.ready only drops when both buffer words are held by a stalled consumer.
// There are no configuration registers.
`default_nettype none

module sync_framed_command_parser (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sfcp_rx_if.sink     rx,
    sfcp_res_if.source  frame
);
    import sfcp_pkg::*;

    logic    buf_ready;
    logic    accept;
    logic    res_valid;
    result_t res_data;
    result_t out_data;

    // A byte is taken whenever the result buffer has a free word, so even a
    // check byte can always hand its result over.
    assign rx.ready = buf_ready;
    assign accept   = rx.valid && buf_ready;

    sfcp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    sfcp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .can_push  (buf_ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_data  (out_data)
    );

    assign frame.frame_status = out_data.frame_status;
    assign frame.device_id    = out_data.device_id;
    assign frame.command      = out_data.command;

endmodule

`default_nettype wire

>>> tb/sv/sfcp_frame_checker.sv
// Scoreboard for the sync-framed command parser: watches both channels, predicts frames.
// Depends on sfcp_pkg and on the sfcp_rx_if and sfcp_res_if interfaces.

module sfcp_frame_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    sfcp_rx_if        rx,
    sfcp_res_if       frame,
    output int        fail_count,
    output int        frames_pending
);
    import sfcp_pkg::*;

    localparam int          ReportLimit = 10;
    localparam logic [15:0] CheckMod    = 16'd255;

    typedef enum logic [2:0] {
        PhSync1,
        PhSync2,
        PhId,
        PhLenHi,
        PhLenLo,
        PhPayload,
        PhCheck
    } phase_e;

    // Shadow copy of the parser state.
    phase_e      phase;
    dev_t        dev_q;
    logic [15:0] sum_q;
    byte_t       len_hi_q;
    logic [15:0] len_q;
    logic [15:0] count_q;
    byte_t       first_q;
    byte_t       second_q;

    result_t frames_due[$];

    function automatic void log_failure(string what, result_t got, result_t want,
                                        bit have_want);
        fail_count++;
        if (fail_count <= ReportLimit) begin
            if (have_want)
                $display("%0t: %s: expected status %0d device %0d command %0d, got %0d %0d %0d",
                         $time, what, want.frame_status, want.device_id, want.command,
                         got.frame_status, got.device_id, got.command);
            else
                $display("%0t: %s: got status %0d device %0d command %0d",
                         $time, what, got.frame_status, got.device_id, got.command);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        byte_t   b;
        logic    sum_ok;
        result_t due;
        result_t got;

        if (!rst_n) begin
            phase    = PhSync1;
            dev_q    = '0;
            sum_q    = '0;
            len_hi_q = '0;
            len_q    = '0;
            count_q  = '0;
            first_q  = '0;
            second_q = '0;
            frames_due.delete();
            fail_count = 0;
            frames_pending <= 0;
        end else begin
            if (rx.valid && rx.ready) begin
                b = rx.rx_byte;
                case (phase)
                    PhSync1: begin
                        if (b == SyncByte) begin
                            phase   = PhSync2;
                            sum_q   = '0;
                            count_q = '0;
                        end
                    end
                    PhSync2: phase = (b == SyncByte) ? PhId : PhSync1;
                    PhId: begin
                        if (b inside {DevPick, DevShoot, DevRanging}) begin
                            dev_q = b[2:0];
                            sum_q = sum_q + {8'h00, b};
                            phase = PhLenHi;
                        end else begin
                            phase = PhSync1;
                        end
                    end
                    PhLenHi: begin
                        sum_q    = sum_q + {8'h00, b};
                        len_hi_q = b;
                        phase    = PhLenLo;
                    end
                    PhLenLo: begin
                        sum_q = sum_q + {8'h00, b};
                        len_q = {len_hi_q, b};
                        phase = PhPayload;
                    end
                    PhPayload: begin
                        sum_q = sum_q + {8'h00, b};
                        if (count_q == 16'd0)
                            first_q = b;
                        else if (count_q == 16'd1)
                            second_q = b;
                        count_q = count_q + 16'd1;
                        if (count_q >= len_q)
                            phase = PhCheck;
                    end
                    PhCheck: begin
                        sum_ok           = ((sum_q % CheckMod) == {8'h00, b});
                        due.frame_status = sum_ok ? StatusOk : StatusBadSum;
                        due.device_id    = dev_q;
                        due.command      = CmdNone;
                        if (sum_ok && first_q == ReqMarker) begin
                            case (dev_q)
                                DevPick: begin
                                    if (second_q >= CmdGetBall && second_q <= CmdDownFromHold)
                                        due.command = second_q[3:0];
                                end
                                DevShoot:   due.command = CmdShoot;
                                DevRanging: due.command = CmdReport;
                                default:    due.command = CmdNone;
                            endcase
                        end
                        frames_due.push_back(due);
                        phase = PhSync1;
                    end
                    default: phase = PhSync1;
                endcase
            end

            if (frame.valid && frame.ready) begin
                got.frame_status = frame.frame_status;
                got.device_id    = frame.device_id;
                got.command      = frame.command;
                if (frames_due.size() == 0) begin
                    log_failure("unexpected frame", got, got, 1'b0);
                end else begin
                    due = frames_due.pop_front();
                    if (got.frame_status !== due.frame_status ||
                        got.device_id !== due.device_id ||
                        got.command !== due.command)
                        log_failure("frame mismatch", got, due, 1'b1);
                end
            end

            frames_pending <= frames_due.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the sync-framed command parser testbench: clock, reset, stimulus and verdict.
// Depends on sfcp_pkg, the channel interfaces, the parser and sfcp_frame_checker.

module tb_top;
    import sfcp_pkg::*;

    // The limit sits well above the length of a run in which every byte waits out
    // the longest idle gap.
    localparam int CycleLimit = 200_000;
    // Length of the deliberate consumer hold-off, in cycles.
    localparam int HoldCycles = 300;
    // Cycles allowed after the last frame for anything stray to show up.
    localparam int SettleCycles = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int frames_pending;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int stop_at;

    // When steady is set neither side idles, which gives stretches of full rate.
    bit steady   = 1'b0;
    // The sender raises hold_req; the consumer answers with holding while it stalls.
    bit hold_req = 1'b0;
    bit holding  = 1'b0;

    sfcp_rx_if  rx_ch ();
    sfcp_res_if res_ch ();

    sync_framed_command_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (res_ch)
    );

    sfcp_frame_checker frame_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_ch),
        .frame          (res_ch),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: a hung handshake or a frame that never arrives ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle length for either side. Most gaps are zero or short, a few are long.
    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one word and returns at the clock edge where it is taken. The valid line
    // is left high, so a following call in the same time step just replaces the data.
    // A gap lowers valid first, which always happens in a different time step from
    // the raise that follows it.
    task automatic send_byte(input byte_t b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    // Sends one whole frame. A length of zero still carries one payload byte. Payload
    // bytes past the second are random. A negative check sends the correct sum mod 255.
    task automatic send_frame(input byte_t id, input logic [15:0] len, input byte_t p0,
                              input byte_t p1, input int check);
        logic [15:0] sum;
        int          body;
        int          i;
        byte_t       b;
        body = (len == 16'd0) ? 1 : int'(len);
        sum  = {8'h00, id} + {8'h00, len[15:8]} + {8'h00, len[7:0]};
        send_byte(SyncByte);
        send_byte(SyncByte);
        send_byte(id);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (i = 0; i < body; i++) begin
            b   = (i == 0) ? p0 : (i == 1) ? p1 : byte_t'($urandom);
            sum = sum + {8'h00, b};
            send_byte(b);
        end
        send_byte((check < 0) ? byte_t'(sum % 16'd255) : byte_t'(check));
    endtask

    // Drops valid and holds off until every predicted frame has been delivered.
    task automatic wait_for_drain();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (frames_pending != 0);
    endtask

    // One random chunk of traffic. Most of it is well-formed frames with random
    // contents; the rest is broken headers and line noise. Every broken header ends
    // on a byte that puts the parser back into its hunt, and noise never holds the
    // sync value, so the next frame always lines up.
    task automatic random_sequence();
        int          r;
        int          n;
        logic [15:0] len;
        byte_t       p0;
        byte_t       p1;
        byte_t       bad_id;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            steady = ($urandom_range(0, 9) == 0);
            n = $urandom_range(0, 99);
            if (n < 70)
                len = 16'($urandom_range(0, 3));
            else if (n < 95)
                len = 16'($urandom_range(4, 24));
            else
                len = 16'($urandom_range(25, 60));
            // Mostly real requests, with the second byte near the valid command range.
            p0 = ($urandom_range(0, 9) < 7) ? ReqMarker : byte_t'($urandom);
            p1 = ($urandom_range(0, 9) < 6) ? byte_t'($urandom_range(0, 8))
                                            : byte_t'($urandom);
            send_frame(byte_t'($urandom_range(2, 4)), len, p0, p1,
                       ($urandom_range(0, 99) < 85) ? -1 : int'($urandom_range(0, 255)));
            steady = 1'b0;
        end else if (r < 85) begin
            // Sync byte followed by anything else.
            send_byte(SyncByte);
            send_byte(byte_t'($urandom_range(0, 254)));
        end else if (r < 90) begin
            // Full sync pair but a device id that is not served here.
            do bad_id = byte_t'($urandom); while (bad_id inside {DevPick, DevShoot, DevRanging});
            send_byte(SyncByte);
            send_byte(SyncByte);
            send_byte(bad_id);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(byte_t'($urandom_range(0, 254)));
        end
    endtask

    // Consumer side: runs of ready, random stalls, and the long hold-off on request.
    initial
    begin : consumer
        int span;
        res_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                holding = 1'b1;
                repeat (HoldCycles) @(posedge clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end else begin
                span = idle_gap();
                if (span > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        wait (rst_n);
        @(posedge clk);

        // Directed part. A sync byte followed by a zero sends the parser back to its
        // hunt, as does a full sync pair with an unknown device id.
        send_byte(SyncByte);
        send_byte(8'h00);
        send_byte(SyncByte);
        send_byte(SyncByte);
        send_byte(8'h05);
        // A plain pick request with the highest pick command.
        send_frame(byte_t'(DevPick), 16'd2, ReqMarker, byte_t'(CmdDownFromHold), -1);
        // Zero length: exactly one payload byte is taken.
        send_frame(byte_t'(DevShoot), 16'd0, ReqMarker, 8'h00, -1);
        // One-byte payload: the second payload byte from the first frame still counts.
        send_frame(byte_t'(DevPick), 16'd1, ReqMarker, 8'h00, -1);
        // A check byte of all ones can never match the reduced sum.
        send_frame(byte_t'(DevRanging), 16'd2, ReqMarker, 8'hFF, 8'hFF);

        // First half of the random traffic.
        stop_at = bytes_sent + 250;
        while (bytes_sent < stop_at)
            random_sequence();

        // Long consumer stall while the sender keeps offering short frames at full
        // rate. The output buffer fills and the parser has to push back on rx.
        hold_req = 1'b1;
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (!holding);
        steady = 1'b1;
        repeat (8)
            send_frame(byte_t'($urandom_range(2, 4)), 16'($urandom_range(0, 2)), ReqMarker,
                       byte_t'($urandom_range(1, 6)), -1);
        steady = 1'b0;

        // Sender stays quiet until the backlog has fully drained.
        wait_for_drain();

        // Second half of the random traffic.
        stop_at = bytes_sent + 250;
        while (bytes_sent < stop_at)
            random_sequence();

        // All frames must come back, then a short settle for anything unexpected.
        wait_for_drain();
        repeat (SettleCycles) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
